### src/ucb1_arm_selector_assert.svh
// Assertion macros for the UCB1 arm selector.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef UCB1_ARM_SELECTOR_ASSERT_SVH
`define UCB1_ARM_SELECTOR_ASSERT_SVH
`ifndef SYNTH
`define UCB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UCB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UCB_ASSERT(name, prop, msg)
`define UCB_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

### src/ucb_pkg.sv
// Shared constants and codes for the UCB1 arm selector.
// No dependencies.
package ucb_pkg;
  localparam int NUM_ARMS_W = 9;
  localparam int GAIN_W     = 16;
  localparam int ARM_OUT_W  = 8;
  localparam int PLAY_W     = 16;
  localparam int LNQ_W      = 21;
  localparam int FRAC_W     = 17;
  localparam int SQ_IN_W    = 38;
  localparam int ROOT_W     = SQ_IN_W / 2;
  localparam int BONUS_W    = GAIN_W + ROOT_W;
  localparam int SCORE_W    = 24;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic [NUM_ARMS_W-1:0] NUM_ARMS_RST = 9'd1;
  localparam logic                  SIDE_WHITE_RST = 1'b1;
  localparam logic [GAIN_W-1:0]     GAIN_RST = 16'd6144;

  typedef enum logic [1:0] {
    CFG_NUM_ARMS     = 2'd0,
    CFG_SIDE_WHITE   = 2'd1,
    CFG_EXPLORE_GAIN = 2'd2
  } cfg_idx_t;

  localparam logic       OP_START   = 1'b0;
  localparam logic       OP_REPORT  = 1'b1;
  localparam logic [1:0] RES_WHITE  = 2'b01;
  localparam logic [1:0] RES_BLACK  = 2'b11;
endpackage

### src/ucb_if.sv
// Channel interfaces for the UCB1 arm selector: input, result and configuration.
// Depends on nothing.
interface ucb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] outcome;
  modport source (output valid, opcode, outcome, input ready);
  modport sink   (input valid, opcode, outcome, output ready);
endinterface

interface ucb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  next_arm;
  logic [7:0]  best_arm;
  logic [15:0] playouts_done;
  modport source (output valid, next_arm, best_arm, playouts_done, input ready);
  modport sink   (input valid, next_arm, best_arm, playouts_done, output ready);
endinterface

interface ucb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/ucb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ucb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/ucb_div.sv
// Restoring divider, one quotient bit per cycle, shared for all divisions.
// No dependencies.
module ucb_div #(
  parameter int W  = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [W-1:0]  quot
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [W-1:0]  quo_r;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_diff;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_diff = rem_sh - {1'b0, dsr_r};
    rem_nxt  = ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        quo_r <= {quo_r[W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

### src/ucb_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// No dependencies.
module ucb_isqrt #(
  parameter int W = 38
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   val,
  output logic           done,
  output logic [W/2-1:0] root
);
  logic         busy_r;
  logic         done_r;
  logic [W-1:0] v_r;
  logic [W-1:0] r_r;
  logic [W-1:0] bit_r;
  logic [W-1:0] sum;

  assign sum = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= val;
        r_r    <= '0;
        bit_r  <= {2'b01, {(W-2){1'b0}}};
      end else if (busy_r) begin
        if (v_r >= sum) begin
          v_r <= v_r - sum;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[W/2-1:0];
endmodule

### src/ucb_ln.sv
// Natural logarithm in Q16 of a counter: normalise, sixteen squaring rounds, scale by ln 2.
// Depends on ucb_pkg.
module ucb_ln #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [COUNT_BITS-1:0]   n,
  output logic                    done,
  output logic [ucb_pkg::LNQ_W-1:0] lnq
);
  import ucb_pkg::*;

  localparam int KW = $clog2(COUNT_BITS);

  typedef enum logic [2:0] {
    L_IDLE, L_NORM, L_MUL, L_CHK, L_SCALE, L_FIN
  } ln_state_t;

  ln_state_t               st_r;
  logic                    done_r;
  logic [COUNT_BITS-1:0]   m_r;
  logic [KW-1:0]           k_r;
  logic [30:0]             mant_r;
  logic [15:0]             frac_r;
  logic [3:0]              i_r;
  logic [61:0]             prod_r;
  logic [36:0]             lp_r;
  logic [LNQ_W-1:0]        lnq_r;
  logic [COUNT_BITS+30:0]  wide;
  logic [31:0]             sq;

  assign wide = {m_r, 31'b0};
  assign sq   = prod_r[61:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) begin
            if (n <= COUNT_BITS'(1)) begin
              lnq_r  <= '0;
              done_r <= 1'b1;
            end else begin
              m_r  <= n;
              k_r  <= KW'(COUNT_BITS - 1);
              st_r <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (m_r[COUNT_BITS-1]) begin
            mant_r <= wide[COUNT_BITS+30 -: 31];
            frac_r <= '0;
            i_r    <= 4'd15;
            st_r   <= L_MUL;
          end else begin
            m_r <= m_r << 1;
            k_r <= k_r - KW'(1);
          end
        end
        L_MUL: begin
          prod_r <= mant_r * mant_r;
          st_r   <= L_CHK;
        end
        L_CHK: begin
          if (sq[31]) begin
            mant_r      <= sq[31:1];
            frac_r[i_r] <= 1'b1;
          end else begin
            mant_r <= sq[30:0];
          end
          if (i_r == 4'd0) begin
            st_r <= L_SCALE;
          end else begin
            i_r  <= i_r - 4'd1;
            st_r <= L_MUL;
          end
        end
        L_SCALE: begin
          lp_r <= {5'(k_r), frac_r} * LN2_Q16;
          st_r <= L_FIN;
        end
        L_FIN: begin
          lnq_r  <= lp_r[36:16];
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign lnq  = lnq_r;
endmodule

### src/ucb1_arm_selector.sv
// UCB1 arm selector: counters in RAM, one sequencer over a shared divider, root and log unit.
// A start word clears every counter in the RAM and a report word updates the selected
// arm's counters; then the log unit runs and each active arm is scored through the shared
// divider and square root. One word at a time. After reset a clearing pass runs through
// the counter RAM before the first word is taken.
`include "ucb1_arm_selector_assert.svh"
module ucb1_arm_selector #(
  parameter int MAX_ARMS   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ucb_in_if.sink    in_ch,
  ucb_out_if.source out_ch,
  ucb_cfg_if.sink   cfg_ch
);
  import ucb_pkg::*;

  localparam int AW    = $clog2(MAX_ARMS);
  localparam int ACT_W = $clog2(MAX_ARMS + 1);
  localparam int CB    = COUNT_BITS;
  localparam int DIV_W = CB + 16;
  localparam int RAM_W = 3 * CB;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_UPD, ST_LN, ST_LNW, ST_ARM_RD, ST_ARM_GET,
    ST_FRAC, ST_EVAL, ST_TDIV, ST_SQ, ST_CMP, ST_EMIT
  } state_t;

  state_t                  state_r;
  logic                    item_r;
  logic [AW-1:0]           clr_r;
  logic [NUM_ARMS_W-1:0]   num_arms_r;
  logic                    side_white_r;
  logic [GAIN_W-1:0]       gain_r;
  logic                    op_r;
  logic [1:0]              oc_r;
  logic [CB-1:0]           total_r;
  logic [AW-1:0]           sel_r;
  logic [ACT_W-1:0]        act_r;
  logic [ACT_W-1:0]        arm_r;
  logic [LNQ_W-1:0]        lnq_r;
  logic [CB-1:0]           g_r;
  logic [FRAC_W-1:0]       f_r;
  logic [FRAC_W-1:0]       bfrac_r;
  logic [SCORE_W-1:0]      bscore_r;
  logic [AW-1:0]           best_r;
  logic [AW-1:0]           next_r;
  logic                    found_r;
  logic [BONUS_W-1:0]      bon_r;
  logic                    out_valid_r;
  logic [ARM_OUT_W-1:0]    out_next_r;
  logic [ARM_OUT_W-1:0]    out_best_r;
  logic [PLAY_W-1:0]       out_play_r;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [RAM_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [RAM_W-1:0]        ram_rdata;
  logic [CB-1:0]           rd_games;
  logic [CB-1:0]           rd_white;
  logic [CB-1:0]           rd_black;
  logic [CB-1:0]           rd_mover;
  logic [CB-1:0]           up_games;
  logic [CB-1:0]           up_white;
  logic [CB-1:0]           up_black;

  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [CB-1:0]           div_divisor;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quot;
  logic                    sq_start;
  logic [SQ_IN_W-1:0]      sq_val;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic                    ln_start;
  logic                    ln_done;
  logic [LNQ_W-1:0]        ln_q;

  logic [ACT_W-1:0]        act_nxt;
  logic                    last_arm;
  logic [SCORE_W-1:0]      score;
  logic                    in_acc;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == {CB{1'b1}}) ? v : v + CB'(1);
  endfunction

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (num_arms_r == '0) begin
      act_nxt = ACT_W'(1);
    end else if (32'(num_arms_r) > 32'(MAX_ARMS)) begin
      act_nxt = ACT_W'(MAX_ARMS);
    end else begin
      act_nxt = ACT_W'(num_arms_r);
    end
  end

  assign rd_games = ram_rdata[3*CB-1:2*CB];
  assign rd_white = ram_rdata[2*CB-1:CB];
  assign rd_black = ram_rdata[CB-1:0];
  assign rd_mover = side_white_r ? rd_white : rd_black;
  assign up_games = sat_inc(rd_games);
  assign up_white = (oc_r == RES_WHITE) ? sat_inc(rd_white) : rd_white;
  assign up_black = (oc_r == RES_BLACK) ? sat_inc(rd_black) : rd_black;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel_r;
    ram_wdata = {up_games, up_white, up_black};
    if (state_r == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_UPD) begin
      ram_we = 1'b1;
    end
  end
  assign ram_raddr = (state_r == ST_ARM_RD) ? arm_r[AW-1:0] : sel_r;

  assign div_start    = ((state_r == ST_ARM_GET) && (rd_games != '0)) ||
                        ((state_r == ST_EVAL) && !found_r && (g_r != '0) &&
                         (total_r != '0));
  assign div_dividend = (state_r == ST_ARM_GET) ? {rd_mover, 16'b0} : DIV_W'(lnq_r);
  assign div_divisor  = (state_r == ST_ARM_GET) ? rd_games : g_r;
  assign sq_start     = (state_r == ST_TDIV) && div_done;
  assign sq_val       = SQ_IN_W'({div_quot[LNQ_W-1:0], 16'b0});
  assign ln_start     = (state_r == ST_LN);
  assign last_arm     = (arm_r == act_r - ACT_W'(1));
  assign score        = SCORE_W'(f_r) + SCORE_W'(bon_r[BONUS_W-1:12]);

  ucb_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ARMS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ucb_div #(.W(DIV_W), .DW(CB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  ucb_isqrt #(.W(SQ_IN_W)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  ucb_ln #(.COUNT_BITS(CB)) u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_start),
    .n     (total_r),
    .done  (ln_done),
    .lnq   (ln_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      item_r       <= 1'b0;
      clr_r        <= '0;
      num_arms_r   <= NUM_ARMS_RST;
      side_white_r <= SIDE_WHITE_RST;
      gain_r       <= GAIN_RST;
      total_r      <= '0;
      sel_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_NUM_ARMS:     num_arms_r   <= cfg_ch.data[NUM_ARMS_W-1:0];
          CFG_SIDE_WHITE:   side_white_r <= cfg_ch.data[0];
          CFG_EXPLORE_GAIN: gain_r       <= cfg_ch.data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_ARMS - 1)) begin
            clr_r   <= '0;
            total_r <= '0;
            state_r <= item_r ? ST_LN : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            item_r  <= 1'b1;
            op_r    <= in_ch.opcode;
            oc_r    <= in_ch.outcome;
            act_r   <= act_nxt;
            state_r <= (in_ch.opcode == OP_START) ? ST_CLR : ST_RD;
          end
        end
        ST_RD: state_r <= ST_UPD;
        ST_UPD: begin
          total_r <= sat_inc(total_r);
          state_r <= ST_LN;
        end
        ST_LN: state_r <= ST_LNW;
        ST_LNW: begin
          if (ln_done) begin
            lnq_r   <= ln_q;
            arm_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_ARM_RD;
          end
        end
        ST_ARM_RD: state_r <= ST_ARM_GET;
        ST_ARM_GET: begin
          g_r <= rd_games;
          if (rd_games == '0) begin
            f_r     <= '0;
            state_r <= ST_EVAL;
          end else begin
            state_r <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          if (div_done) begin
            f_r     <= div_quot[FRAC_W-1:0];
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if ((arm_r == '0) || (f_r > bfrac_r)) begin
            bfrac_r <= f_r;
            best_r  <= arm_r[AW-1:0];
          end
          if (found_r) begin
            state_r <= last_arm ? ST_EMIT : ST_ARM_RD;
            arm_r   <= arm_r + ACT_W'(1);
          end else if ((g_r == '0) || (total_r == '0)) begin
            found_r <= 1'b1;
            next_r  <= arm_r[AW-1:0];
            state_r <= last_arm ? ST_EMIT : ST_ARM_RD;
            arm_r   <= arm_r + ACT_W'(1);
          end else begin
            state_r <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            state_r <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (sq_done) begin
            bon_r   <= gain_r * sq_root;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if ((arm_r == '0) || (score > bscore_r)) begin
            bscore_r <= score;
            next_r   <= arm_r[AW-1:0];
          end
          state_r <= last_arm ? ST_EMIT : ST_ARM_RD;
          arm_r   <= arm_r + ACT_W'(1);
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_next_r  <= ARM_OUT_W'(next_r);
            out_best_r  <= ARM_OUT_W'(best_r);
            out_play_r  <= (32'(total_r) > 32'hFFFF) ? 16'hFFFF : PLAY_W'(total_r);
            sel_r       <= next_r;
            item_r      <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_arm      = out_next_r;
  assign out_ch.best_arm      = out_best_r;
  assign out_ch.playouts_done = out_play_r;

  `UCB_ASSERT(a_busy_after_accept, in_acc |=> !in_ch.ready, "Ready stayed high after a word was taken")
  `UCB_ASSERT(a_scan_in_range, (state_r == ST_EVAL) |-> (arm_r < act_r), "Arm scan ran past the active arms")
  `UCB_ASSERT(a_result_from_emit, $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT), "Result raised outside the emit step")
  `UCB_ASSERT(a_op_path, ((state_r == ST_RD) |-> (op_r == OP_REPORT)), "Counter update for a start word")
  `UCB_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_ch.valid, "Result valid after reset")
endmodule
